@@ design/preemptive_priority_scheduler_macros.svh @@
// assertion macros used by the scheduler controller rtl
// no dependencies; expects i_clk and i_rst_n in the including module
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// same-cycle implication, checked out of reset
`define PPSCH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PPSCH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ppsch_pkg.sv @@
// shared constants, codes and structs of the priority scheduler
// no dependencies
package ppsch_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_STEP  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // one table entry; left is the remaining burst
    typedef struct packed {
        logic [7:0]  task_id;
        logic [15:0] arrival;
        logic [15:0] left;
        logic [7:0]  urgency;
    } t_entry;

    typedef struct packed {
        logic [7:0]  slice_task;
        logic [31:0] slice_start;
        logic [15:0] slice_length;
        logic [7:0]  slice_urgency;
        logic        is_gap;
        logic        all_done;
    } t_slice;

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic             clear;
        logic             scan_start;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             eval;
        logic [IDX_W-1:0] eval_idx;
        logic             commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0] count;
    } t_status;

endpackage

@@ design/ppsch_if.sv @@
// valid/ready channels of the priority scheduler
// depends on ppsch_pkg
interface ppsch_in_if;
    logic              valid;
    logic              ready;
    ppsch_pkg::t_op    op;
    logic [7:0]        task_id;
    logic [15:0]       arrival;
    logic [15:0]       burst;
    logic [7:0]        urgency;

    modport source (output valid, op, task_id, arrival, burst, urgency, input ready);
    modport sink   (input valid, op, task_id, arrival, burst, urgency, output ready);
endinterface

interface ppsch_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  slice_task;
    logic [31:0] slice_start;
    logic [15:0] slice_length;
    logic [7:0]  slice_urgency;
    logic        is_gap;
    logic        all_done;

    modport source (output valid, slice_task, slice_start, slice_length, slice_urgency,
                    is_gap, all_done, input ready);
    modport sink   (input valid, slice_task, slice_start, slice_length, slice_urgency,
                    is_gap, all_done, output ready);
endinterface

@@ design/ppsch_ctrl.sv @@
// controller fsm: accepts words, sequences the table scan, owns output valid
// depends on ppsch_pkg and preemptive_priority_scheduler_macros.svh
`include "preemptive_priority_scheduler_macros.svh"

module ppsch_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  ppsch_pkg::t_op      i_in_op,
    input  logic                i_out_ready,
    input  ppsch_pkg::t_status  i_status,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output ppsch_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    logic [ppsch_pkg::CNT_W-1:0]   r_idx, n_idx;
    logic                          r_ev, n_ev;
    logic [ppsch_pkg::IDX_W-1:0]   r_ev_idx, n_ev_idx;
    logic                          r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_ev        = r_ev;
        n_ev_idx    = r_ev_idx;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_op)
                        ppsch_pkg::OP_LOAD: begin
                            o_cmd.load = 1'b1;
                        end
                        ppsch_pkg::OP_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        ppsch_pkg::OP_STEP: begin
                            o_cmd.scan_start = 1'b1;
                            n_idx            = '0;
                            n_ev             = 1'b0;
                            n_state          = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // read issued one cycle, evaluated the next
                o_cmd.eval     = r_ev;
                o_cmd.eval_idx = r_ev_idx;
                if (r_idx < i_status.count) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = r_idx[ppsch_pkg::IDX_W-1:0];
                    n_idx         = r_idx + ppsch_pkg::CNT_W'(1);
                    n_ev          = 1'b1;
                    n_ev_idx      = r_idx[ppsch_pkg::IDX_W-1:0];
                end else begin
                    n_ev = 1'b0;
                    if (!r_ev) begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_ev        <= 1'b0;
            r_ev_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_ev        <= n_ev;
            r_ev_idx    <= n_ev_idx;
            r_out_valid <= n_out_valid;
        end
    end

    `PPSCH_ASSERT_NOW(a_scan_idx_bound, r_state == ST_SCAN, r_idx <= i_status.count, "scan index past entry count")
    `PPSCH_ASSERT_NEXT(a_read_then_eval, (r_state == ST_SCAN) && (r_idx < i_status.count), r_ev, "table read not followed by evaluation")
    `PPSCH_ASSERT_NEXT(a_commit_sets_valid, o_cmd.commit, r_out_valid, "committed slice not presented")

endmodule

@@ design/ppsch_dp.sv @@
// datapath: task table memory, best-task search registers, time and output word
// depends on ppsch_pkg
module ppsch_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ppsch_pkg::t_cmd     i_cmd,
    input  ppsch_pkg::t_entry   i_load,
    output ppsch_pkg::t_status  o_status,
    output ppsch_pkg::t_slice   o_slice
);

    ppsch_pkg::t_entry             r_mem [ppsch_pkg::SLOTS];
    ppsch_pkg::t_entry             r_rd_data;
    logic [ppsch_pkg::CNT_W-1:0]   r_count;
    logic [31:0]                   r_now;
    logic                          r_found;
    logic                          r_pending;
    ppsch_pkg::t_entry             r_best;
    logic [ppsch_pkg::IDX_W-1:0]   r_pick;
    logic [15:0]                   r_next;
    ppsch_pkg::t_slice             r_slice;

    logic                          w_full;
    logic                          w_load_ok;
    logic                          w_we;
    logic [ppsch_pkg::IDX_W-1:0]   w_waddr;
    ppsch_pkg::t_entry             w_wdata;
    logic                          w_live;
    logic                          w_arrived;
    logic                          w_take;
    logic                          w_later;

    assign w_full    = (r_count == ppsch_pkg::CNT_W'(ppsch_pkg::SLOTS));
    assign w_load_ok = i_cmd.load && !w_full;

    // write port: loads append, a run slice decrements the picked entry
    always_comb begin
        w_wdata = i_load;
        w_waddr = r_count[ppsch_pkg::IDX_W-1:0];
        w_we    = w_load_ok;
        if (i_cmd.commit && r_found) begin
            w_wdata      = r_best;
            w_wdata.left = r_best.left - 16'd1;
            w_waddr      = r_pick;
            w_we         = 1'b1;
        end
    end

    // candidate test on the entry read last cycle
    assign w_live    = (r_rd_data.left != 16'd0);
    assign w_arrived = ({16'd0, r_rd_data.arrival} <= r_now);
    assign w_take    = w_live && w_arrived && (!r_found || (r_rd_data.urgency < r_best.urgency));
    assign w_later   = w_live && !w_arrived && (!r_pending || (r_rd_data.arrival < r_next));

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_now     <= '0;
            r_found   <= 1'b0;
            r_pending <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
                r_now   <= '0;
            end else if (w_load_ok) begin
                r_count <= r_count + ppsch_pkg::CNT_W'(1);
            end
            if (i_cmd.scan_start) begin
                r_found   <= 1'b0;
                r_pending <= 1'b0;
            end else if (i_cmd.eval) begin
                if (w_take) begin
                    r_found <= 1'b1;
                end
                if (w_later) begin
                    r_pending <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                if (r_found) begin
                    r_now <= r_now + 32'd1;
                end else if (r_pending) begin
                    r_now <= {16'd0, r_next};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval && w_take) begin
            r_best <= r_rd_data;
            r_pick <= i_cmd.eval_idx;
        end
        if (i_cmd.eval && w_later) begin
            r_next <= r_rd_data.arrival;
        end
        if (i_cmd.commit) begin
            r_slice.slice_start <= r_now;
            if (r_found) begin
                r_slice.slice_task    <= r_best.task_id;
                r_slice.slice_length  <= 16'd1;
                r_slice.slice_urgency <= r_best.urgency;
                r_slice.is_gap        <= 1'b0;
                r_slice.all_done      <= 1'b0;
            end else if (r_pending) begin
                r_slice.slice_task    <= 8'd0;
                r_slice.slice_length  <= r_next - r_now[15:0];
                r_slice.slice_urgency <= 8'd0;
                r_slice.is_gap        <= 1'b1;
                r_slice.all_done      <= 1'b0;
            end else begin
                r_slice.slice_task    <= 8'd0;
                r_slice.slice_length  <= 16'd0;
                r_slice.slice_urgency <= 8'd0;
                r_slice.is_gap        <= 1'b0;
                r_slice.all_done      <= 1'b1;
            end
        end
    end

    assign o_status.count = r_count;
    assign o_slice        = r_slice;

endmodule

@@ design/preemptive_priority_scheduler.sv @@
// top level of the preemptive priority scheduler: controller plus datapath
// depends on ppsch_pkg, ppsch_if, ppsch_ctrl and ppsch_dp
//
//  channel  | dir | handshake         | word
//  ---------+-----+-------------------+-----------------------------------------------
//  i_in     | in  | valid/ready       | op, task_id, arrival, burst, urgency
//  o_out    | out | valid/ready       | slice_task, slice_start, slice_length,
//           |     |                   | slice_urgency, is_gap, all_done
//
//  load, clear and the unused op are taken in the idle state and give no word
//  a step reads the task table through its single read port, one entry per cycle,
//    evaluates each entry from the registered read data, drains the last
//    evaluation, then commits its word in the finish state
//  reset (synchronous, active low) empties the table and zeroes the time;
//    table contents are unknown until loaded
//  a finished word waits in the output register while further words are taken;
//    a second step holds in its final cycle until the pending word is taken
module preemptive_priority_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ppsch_in_if.sink    i_in,
    ppsch_out_if.source o_out
);

    ppsch_pkg::t_cmd    w_cmd;
    ppsch_pkg::t_status w_status;
    ppsch_pkg::t_entry  w_load;
    ppsch_pkg::t_slice  w_slice;
    logic               w_in_ready;
    logic               w_out_valid;

    // incoming task fields map straight onto a table entry
    assign w_load.task_id = i_in.task_id;
    assign w_load.arrival = i_in.arrival;
    assign w_load.left    = i_in.burst;
    assign w_load.urgency = i_in.urgency;

    ppsch_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.op),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    ppsch_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_load   (w_load),
        .o_status (w_status),
        .o_slice  (w_slice)
    );

    assign i_in.ready          = w_in_ready;
    assign o_out.valid         = w_out_valid;
    assign o_out.slice_task    = w_slice.slice_task;
    assign o_out.slice_start   = w_slice.slice_start;
    assign o_out.slice_length  = w_slice.slice_length;
    assign o_out.slice_urgency = w_slice.slice_urgency;
    assign o_out.is_gap        = w_slice.is_gap;
    assign o_out.all_done      = w_slice.all_done;

endmodule
